// ===== src/graphic_eq_band_leg_filter_unit_defines.svh =====
// Assertion macros shared by the equalizer RTL
`ifndef GRAPHIC_EQ_BAND_LEG_FILTER_UNIT_DEFINES_SVH
`define GRAPHIC_EQ_BAND_LEG_FILTER_UNIT_DEFINES_SVH
`ifndef SYNTH
`define GEQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define GEQ_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define GEQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define GEQ_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== src/geq_pkg.sv =====
package geq_pkg;
  localparam int unsigned COEFS_PER_BAND = 8;
  localparam int unsigned ACC_W = 64;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_COEF   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    CFG_IN_GAIN   = 2'd0,
    CFG_VOLUME    = 2'd1,
    CFG_IN_SCALE  = 2'd2,
    CFG_HIST_SCALE = 2'd3
  } cfg_idx_e;

  // coefficient slots per band
  localparam logic [2:0] C_GA_D  = 3'd0;
  localparam logic [2:0] C_GB_D  = 3'd1;
  localparam logic [2:0] C_YZ_D  = 3'd2;
  localparam logic [2:0] C_YZ    = 3'd3;
  localparam logic [2:0] C_ZC    = 3'd4;
  localparam logic [2:0] C_ZL    = 3'd5;
  localparam logic [2:0] C_ECOEF = 3'd6;
  localparam logic [2:0] C_KHIST = 3'd7;

  // multiplier operand a select
  typedef enum logic [2:0] {
    MA_X, MA_VIN, MA_VOUT, MA_IPREV, MA_E, MA_T, MA_ONE, MA_HIST
  } mul_a_e;

  // multiplier operand b select
  typedef enum logic [1:0] {
    MB_COEF, MB_CFG, MB_POW2
  } mul_b_e;

  // accumulator operation after a product lands
  typedef enum logic [3:0] {
    AC_LOAD, AC_ADD, AC_NEGLOAD, AC_SUB_E, AC_NONE
  } acc_op_e;

  typedef struct packed {
    logic       start;
    mul_a_e     a_sel;
    mul_b_e     b_sel;
    logic [1:0] cfg_sel;
    logic [5:0] shift;
    logic       pow2_up;
  } mul_cmd_t;

  localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) sat_add = s[64] ? S64_MIN : S64_MAX;
    else sat_add = s[63:0];
  endfunction

  function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) sat_sub = s[64] ? S64_MIN : S64_MAX;
    else sat_sub = s[63:0];
  endfunction

  function automatic logic [63:0] sat_neg(input logic [63:0] a);
    sat_neg = (a == S64_MIN) ? S64_MAX : (64'd0 - a);
  endfunction
endpackage

// ===== src/geq_if.sv =====
// valid/ready stream channel with a generic payload
interface geq_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/geq_ram.sv =====
// simple dual port RAM (one write port, one read port), registered read
module geq_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 80
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== src/geq_mul.sv =====
`include "graphic_eq_band_leg_filter_unit_defines.svh"
// Sequential signed 64x64 multiply: four 32x32 partial products, one per cycle,
// then round half away from zero, shift and saturate to 64 bits.
module geq_mul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  input  logic [5:0]  shift_i,
  output logic        done_o,
  output logic [63:0] p_o
);
  logic [63:0]  ua_q, ua_d, ub_q, ub_d;
  logic         neg_q, neg_d;
  logic [5:0]   sh_q, sh_d;
  logic [127:0] acc_q, acc_d;
  logic [2:0]   step_q, step_d;
  logic         busy_q, busy_d;
  logic         done_q, done_d;
  logic [63:0]  p_q, p_d;
  logic [31:0]  pa, pb;
  logic [63:0]  pp;
  logic [127:0] ppx, rnd, shifted;
  logic [63:0]  lim;

  assign pp = {32'd0, pa} * {32'd0, pb};

  always_comb begin
    pa = ua_q[31:0];
    pb = ub_q[31:0];
    ppx = {64'd0, pp};
    case (step_q)
      3'd0: begin pa = ua_q[31:0];  pb = ub_q[31:0];  ppx = {64'd0, pp}; end
      3'd1: begin pa = ua_q[31:0];  pb = ub_q[63:32]; ppx = {32'd0, pp, 32'd0}; end
      3'd2: begin pa = ua_q[63:32]; pb = ub_q[31:0];  ppx = {32'd0, pp, 32'd0}; end
      3'd3: begin pa = ua_q[63:32]; pb = ub_q[63:32]; ppx = {pp, 64'd0}; end
      default: begin pa = 32'd0; pb = 32'd0; ppx = 128'd0; end
    endcase
  end

  always_comb begin
    rnd = acc_q;
    if (sh_q != 6'd0) rnd = acc_q + (128'd1 << (sh_q - 6'd1));
    shifted = rnd >> sh_q;
    lim = neg_q ? geq_pkg::S64_MIN : geq_pkg::S64_MAX;
  end

  always_comb begin
    ua_d = ua_q; ub_d = ub_q; neg_d = neg_q; sh_d = sh_q;
    acc_d = acc_q; step_d = step_q; busy_d = busy_q; done_d = 1'b0; p_d = p_q;
    if (start_i) begin
      ua_d   = a_i[63] ? (64'd0 - a_i) : a_i;
      ub_d   = b_i[63] ? (64'd0 - b_i) : b_i;
      neg_d  = a_i[63] ^ b_i[63];
      sh_d   = shift_i;
      acc_d  = 128'd0;
      step_d = 3'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (step_q == 3'd4) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        if (shifted[127:64] != 64'd0 || shifted[63:0] > lim) p_d = neg_q ? lim : lim;
        else p_d = neg_q ? (64'd0 - shifted[63:0]) : shifted[63:0];
        if (shifted[127:64] != 64'd0 || shifted[63:0] > lim)
          p_d = neg_q ? geq_pkg::S64_MIN : geq_pkg::S64_MAX;
      end else begin
        acc_d  = acc_q + ppx;
        step_d = step_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= 3'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ua_q <= ua_d; ub_q <= ub_d; neg_q <= neg_d; sh_q <= sh_d;
    acc_q <= acc_d; p_q <= p_d;
  end

  assign done_o = done_q;
  assign p_o    = p_q;

  `GEQ_ASSERT(a_done_end, clk_i, rst_ni, done_q |-> !busy_q, "multiplier done while busy")
  `GEQ_ASSERT(a_start_idle, clk_i, rst_ni, start_i |-> !busy_q, "multiplier restarted while busy")
  `GEQ_ASSERT(a_step_rng, clk_i, rst_ni, busy_q |-> step_q <= 3'd4, "multiplier step out of range")
endmodule

// ===== src/geq_datapath.sv =====
// Datapath: leg state registers, coefficient RAM, history RAM, shared multiplier
// and a saturating accumulator. Driven step by step by the controller.
module geq_datapath #(
  parameter int unsigned NUM_BANDS   = 10,
  parameter int unsigned SAMPLE_BITS = 24,
  parameter int unsigned FRAC_BITS   = 40
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration
  input  logic [22:0]                in_gain_i,
  input  logic [22:0]                volume_i,
  input  logic [31:0]                in_scale_i,
  input  logic [31:0]                hist_scale_i,
  // input word
  input  logic                       cap_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic [3:0]                 band_i,
  input  logic [2:0]                 sel_i,
  input  logic [63:0]                value_i,
  // commands
  input  logic                       coef_we_i,
  input  logic                       clear_i,
  input  logic [$clog2(NUM_BANDS*geq_pkg::COEFS_PER_BAND)-1:0] coef_raddr_i,
  input  logic [$clog2(NUM_BANDS)-1:0] band_sel_i,
  input  logic [$clog2(NUM_BANDS)-1:0] hist_raddr_i,
  input  geq_pkg::mul_cmd_t          mul_cmd_i,
  input  logic [3:0]                 op_i,
  input  logic                       hist_we_i,
  input  logic                       out_load_i,
  output logic                       mul_done_o,
  output logic signed [SAMPLE_BITS-1:0] sample_o,
  output logic                       clipped_o
);
  localparam int unsigned CA_W = $clog2(NUM_BANDS*geq_pkg::COEFS_PER_BAND);
  localparam int unsigned BA_W = $clog2(NUM_BANDS);
  localparam int ALIGN = int'(FRAC_BITS) - (int'(SAMPLE_BITS) - 1);

  logic [63:0] vc_q [NUM_BANDS];
  logic [63:0] vl_q [NUM_BANDS];
  logic [63:0] ip_q [NUM_BANDS];
  logic [63:0] x_q, vin_q, vout_q, e_q, t_q, i_q, hist_q;
  logic [SAMPLE_BITS-1:0] smp_q;
  logic signed [SAMPLE_BITS-1:0] out_q;
  logic clip_q;
  logic [63:0] coef, hrd, ma, mb, prod;
  logic [CA_W-1:0] waddr;

  assign waddr = CA_W'({band_i[BA_W-1:0], 3'd0} + {{(CA_W-3){1'b0}}, sel_i});

  geq_ram #(.WIDTH(64), .DEPTH(NUM_BANDS*geq_pkg::COEFS_PER_BAND)) u_coef (
    .clk_i, .we_i(coef_we_i), .waddr_i(waddr), .wdata_i(value_i),
    .raddr_i(coef_raddr_i), .rdata_o(coef)
  );

  // read address runs one step ahead so the history word is ready on load
  geq_ram #(.WIDTH(64), .DEPTH(NUM_BANDS)) u_hist (
    .clk_i, .we_i(hist_we_i), .waddr_i(band_sel_i), .wdata_i(e_q),
    .raddr_i(hist_raddr_i), .rdata_o(hrd)
  );

  // operand selection
  always_comb begin
    case (mul_cmd_i.a_sel)
      geq_pkg::MA_X:     ma = x_q;
      geq_pkg::MA_VIN:   ma = vin_q;
      geq_pkg::MA_VOUT:  ma = vout_q;
      geq_pkg::MA_IPREV: ma = ip_q[band_sel_i];
      geq_pkg::MA_E:     ma = e_q;
      geq_pkg::MA_T:     ma = t_q;
      geq_pkg::MA_ONE:   ma = {{(64-SAMPLE_BITS){smp_q[SAMPLE_BITS-1]}}, smp_q};
      geq_pkg::MA_HIST:  ma = hist_q;
      default:           ma = 64'd0;
    endcase
    case (mul_cmd_i.b_sel)
      geq_pkg::MB_COEF: mb = coef;
      geq_pkg::MB_CFG: begin
        case (mul_cmd_i.cfg_sel)
          geq_pkg::CFG_IN_GAIN:  mb = {41'd0, in_gain_i};
          geq_pkg::CFG_VOLUME:   mb = {41'd0, volume_i};
          geq_pkg::CFG_IN_SCALE: mb = {32'd0, in_scale_i};
          default:               mb = {32'd0, hist_scale_i};
        endcase
      end
      default: mb = mul_cmd_i.pow2_up ? (64'd1 << (ALIGN > 0 ? ALIGN : -ALIGN)) : 64'd1;
    endcase
  end

  geq_mul u_mul (
    .clk_i, .rst_ni, .start_i(mul_cmd_i.start), .a_i(ma), .b_i(mb),
    .shift_i(mul_cmd_i.shift), .done_o(mul_done_o), .p_o(prod)
  );

  // step codes from the controller
  localparam logic [3:0] S_X = 4'd0, S_VIN = 4'd1, S_E1 = 4'd2, S_E2 = 4'd3,
    S_HIST = 4'd4, S_VOUT1 = 4'd5, S_VOUT2 = 4'd6, S_W1 = 4'd7, S_W2 = 4'd8,
    S_W3 = 4'd9, S_I = 4'd10, S_VC = 4'd11, S_VL = 4'd12, S_Y = 4'd13,
    S_ELOAD = 4'd14, S_NONE = 4'd15;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_BANDS; k++) begin
        vc_q[k] <= 64'd0; vl_q[k] <= 64'd0; ip_q[k] <= 64'd0;
      end
    end else if (clear_i) begin
      for (int k = 0; k < NUM_BANDS; k++) begin
        vc_q[k] <= 64'd0; vl_q[k] <= 64'd0; ip_q[k] <= 64'd0;
      end
    end else if (mul_done_o) begin
      case (op_i)
        S_VC: vc_q[band_sel_i] <= geq_pkg::sat_add(vc_q[band_sel_i], prod);
        S_VL: begin
          vl_q[band_sel_i] <= geq_pkg::sat_sub(prod, vl_q[band_sel_i]);
          ip_q[band_sel_i] <= i_q;
        end
        default: ;
      endcase
    end
  end

  // scalar working registers
  always_ff @(posedge clk_i) begin
    if (cap_i) smp_q <= sample_i;
    if (op_i == S_ELOAD) e_q <= hrd;
    if (mul_done_o) begin
      case (op_i)
        S_X:     x_q <= prod;
        S_VIN:   begin vin_q <= prod; hist_q <= 64'd0; end
        S_E1:    e_q <= geq_pkg::sat_sub(geq_pkg::sat_add(vc_q[band_sel_i], prod),
                                         vl_q[band_sel_i]);
        S_HIST:  hist_q <= geq_pkg::sat_add(hist_q, prod);
        S_VOUT1: vout_q <= geq_pkg::sat_neg(prod);
        S_VOUT2: vout_q <= geq_pkg::sat_add(vout_q, prod);
        S_W1:    t_q <= prod;
        S_W2:    t_q <= geq_pkg::sat_add(t_q, prod);
        S_W3:    t_q <= geq_pkg::sat_sub(geq_pkg::sat_add(t_q, prod), e_q);
        S_I: begin
          i_q <= prod;
          t_q <= geq_pkg::sat_add(prod, ip_q[band_sel_i]);
        end
        S_VC:    t_q <= geq_pkg::sat_sub(i_q, ip_q[band_sel_i]);
        S_Y:     t_q <= geq_pkg::sat_neg(prod);
        default: ;
      endcase
    end
  end

  // output saturation
  localparam logic [63:0] LIM_HI = (64'd1 << (SAMPLE_BITS-1)) - 64'd1;
  localparam logic [63:0] LIM_LO = ~LIM_HI;
  always_ff @(posedge clk_i) begin
    if (out_load_i) begin
      if ($signed(prod) > $signed(LIM_HI)) begin
        out_q <= LIM_HI[SAMPLE_BITS-1:0]; clip_q <= 1'b1;
      end else if ($signed(prod) < $signed(LIM_LO)) begin
        out_q <= LIM_LO[SAMPLE_BITS-1:0]; clip_q <= 1'b1;
      end else begin
        out_q <= prod[SAMPLE_BITS-1:0]; clip_q <= 1'b0;
      end
    end
  end

  assign sample_o  = out_q;
  assign clipped_o = clip_q;
endmodule

// ===== src/geq_ctrl.sv =====
// Controller: sequences each sample word through the shared multiplier.
module geq_ctrl #(
  parameter int unsigned NUM_BANDS   = 10,
  parameter int unsigned SAMPLE_BITS = 24,
  parameter int unsigned FRAC_BITS   = 40
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic [1:0] opcode_i,
  input  logic [3:0] band_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic cap_o,
  output logic coef_we_o,
  output logic clear_o,
  output logic [$clog2(NUM_BANDS*geq_pkg::COEFS_PER_BAND)-1:0] coef_raddr_o,
  output logic [$clog2(NUM_BANDS)-1:0] band_sel_o,
  output logic [$clog2(NUM_BANDS)-1:0] hist_raddr_o,
  output geq_pkg::mul_cmd_t mul_cmd_o,
  output logic [3:0] op_o,
  output logic hist_we_o,
  output logic out_load_o,
  input  logic mul_done_i
);
  localparam int unsigned CA_W = $clog2(NUM_BANDS*geq_pkg::COEFS_PER_BAND);
  localparam int unsigned BA_W = $clog2(NUM_BANDS);
  localparam int ALIGN = int'(FRAC_BITS) - (int'(SAMPLE_BITS) - 1);
  localparam logic [5:0] FB = 6'(FRAC_BITS);

  localparam logic [3:0] S_X = 4'd0, S_VIN = 4'd1, S_E1 = 4'd2, S_E2 = 4'd3,
    S_HIST = 4'd4, S_VOUT1 = 4'd5, S_VOUT2 = 4'd6, S_W1 = 4'd7, S_W2 = 4'd8,
    S_W3 = 4'd9, S_I = 4'd10, S_VC = 4'd11, S_VL = 4'd12, S_Y = 4'd13,
    S_ELOAD = 4'd14, S_NONE = 4'd15;

  localparam logic [2:0] ST_IDLE = 3'd0, ST_ISSUE = 3'd1, ST_WAIT = 3'd2,
    ST_OUT = 3'd3, ST_FIN = 3'd4;

  logic [2:0] st_q, st_d;
  logic [3:0] op_q, op_d;
  logic [BA_W-1:0] b_q, b_d;
  logic y2_q, y2_d;
  logic ov_q, ov_d;

  always_comb begin
    st_d = st_q; op_d = op_q; b_d = b_q; y2_d = y2_q; ov_d = ov_q;
    in_ready_o = 1'b0; cap_o = 1'b0; coef_we_o = 1'b0; clear_o = 1'b0;
    hist_we_o = 1'b0; out_load_o = 1'b0;
    mul_cmd_o = '{start: 1'b0, a_sel: geq_pkg::MA_X, b_sel: geq_pkg::MB_COEF,
                  cfg_sel: geq_pkg::CFG_IN_GAIN, shift: 6'd0, pow2_up: 1'b0};
    if (ov_q && out_ready_i) ov_d = 1'b0;
    case (st_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (geq_pkg::opcode_e'(opcode_i))
            geq_pkg::OP_SAMPLE: begin
              cap_o = 1'b1; op_d = S_X; b_d = '0; y2_d = 1'b0; st_d = ST_ISSUE;
            end
            geq_pkg::OP_COEF:  coef_we_o = ({1'b0, band_i} < 5'(NUM_BANDS));
            geq_pkg::OP_CLEAR: clear_o = 1'b1;
            default: ;
          endcase
        end
      end
      ST_ISSUE: begin
        mul_cmd_o.start = 1'b1;
        case (op_q)
          S_X: begin
            mul_cmd_o.a_sel = geq_pkg::MA_ONE; mul_cmd_o.b_sel = geq_pkg::MB_POW2;
            mul_cmd_o.pow2_up = (ALIGN >= 0);
            mul_cmd_o.shift = (ALIGN >= 0) ? 6'd0 : 6'(-ALIGN);
          end
          S_VIN: begin
            mul_cmd_o.a_sel = geq_pkg::MA_X; mul_cmd_o.b_sel = geq_pkg::MB_CFG;
            mul_cmd_o.cfg_sel = geq_pkg::CFG_IN_GAIN; mul_cmd_o.shift = 6'd20;
          end
          S_E1: begin
            mul_cmd_o.a_sel = geq_pkg::MA_IPREV; mul_cmd_o.shift = FB;
          end
          S_HIST: begin
            mul_cmd_o.a_sel = geq_pkg::MA_E; mul_cmd_o.shift = FB;
          end
          S_VOUT1: begin
            mul_cmd_o.a_sel = geq_pkg::MA_VIN; mul_cmd_o.b_sel = geq_pkg::MB_CFG;
            mul_cmd_o.cfg_sel = geq_pkg::CFG_IN_SCALE; mul_cmd_o.shift = 6'd24;
          end
          S_VOUT2: begin
            mul_cmd_o.a_sel = geq_pkg::MA_HIST; mul_cmd_o.b_sel = geq_pkg::MB_CFG;
            mul_cmd_o.cfg_sel = geq_pkg::CFG_HIST_SCALE; mul_cmd_o.shift = 6'd24;
          end
          S_W1: begin mul_cmd_o.a_sel = geq_pkg::MA_VIN; mul_cmd_o.shift = FB; end
          S_W2: begin mul_cmd_o.a_sel = geq_pkg::MA_VOUT; mul_cmd_o.shift = FB; end
          S_W3: begin mul_cmd_o.a_sel = geq_pkg::MA_E; mul_cmd_o.shift = FB; end
          S_I, S_VC, S_VL: begin mul_cmd_o.a_sel = geq_pkg::MA_T; mul_cmd_o.shift = FB; end
          default: begin
            mul_cmd_o.b_sel = geq_pkg::MB_CFG; mul_cmd_o.cfg_sel = geq_pkg::CFG_VOLUME;
            mul_cmd_o.shift = 6'd20;
            if (y2_q) begin
              mul_cmd_o.a_sel = geq_pkg::MA_T; mul_cmd_o.b_sel = geq_pkg::MB_POW2;
              mul_cmd_o.pow2_up = (ALIGN < 0);
              mul_cmd_o.shift = (ALIGN >= 0) ? 6'(ALIGN) : 6'd0;
            end else mul_cmd_o.a_sel = geq_pkg::MA_VOUT;
          end
        endcase
        st_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (mul_done_i) begin
          st_d = ST_ISSUE;
          case (op_q)
            S_X: op_d = S_VIN;
            S_VIN: op_d = S_E1;
            S_E1: begin op_d = S_E2; st_d = ST_FIN; end
            S_HIST: begin
              if (b_q == BA_W'(NUM_BANDS-1)) begin op_d = S_VOUT1; b_d = '0; end
              else begin op_d = S_E1; b_d = b_q + 1'b1; end
            end
            S_VOUT1: op_d = S_VOUT2;
            S_VOUT2: begin op_d = S_ELOAD; st_d = ST_FIN; end
            S_W1: op_d = S_W2;
            S_W2: op_d = S_W3;
            S_W3: op_d = S_I;
            S_I: op_d = S_VC;
            S_VC: op_d = S_VL;
            S_VL: begin
              if (b_q == BA_W'(NUM_BANDS-1)) op_d = S_Y;
              else begin op_d = S_ELOAD; b_d = b_q + 1'b1; st_d = ST_FIN; end
            end
            default: begin
              if (y2_q) st_d = ST_OUT;
              else y2_d = 1'b1;
            end
          endcase
        end
      end
      ST_FIN: begin
        // bookkeeping step between multiplies
        case (op_q)
          S_E2: begin hist_we_o = 1'b1; op_d = S_HIST; st_d = ST_ISSUE; end
          default: begin op_d = S_W1; st_d = ST_ISSUE; end
        endcase
      end
      ST_OUT: begin
        // load the output register once the previous word has left
        if (!ov_q || out_ready_i) begin
          out_load_o = 1'b1; ov_d = 1'b1; st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // ELOAD pulses while in FIN so the history word lands in e
  assign op_o = (st_q == ST_FIN && op_q == S_ELOAD) ? S_ELOAD :
                (st_q == ST_WAIT) ? op_q : S_NONE;
  // RAM reads are registered: address from the next step so data is ready at issue
  assign coef_raddr_o = CA_W'({b_d, 3'd0}) | CA_W'(
    (op_d == S_E1) ? geq_pkg::C_ECOEF : (op_d == S_HIST) ? geq_pkg::C_KHIST :
    (op_d == S_W1) ? geq_pkg::C_GA_D : (op_d == S_W2) ? geq_pkg::C_GB_D :
    (op_d == S_W3) ? geq_pkg::C_YZ_D : (op_d == S_I) ? geq_pkg::C_YZ :
    (op_d == S_VC) ? geq_pkg::C_ZC : geq_pkg::C_ZL);
  assign hist_raddr_o = b_d;
  assign band_sel_o  = b_q;
  assign out_valid_o = ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; op_q <= S_X; b_q <= '0; y2_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; op_q <= op_d; b_q <= b_d; y2_q <= y2_d; ov_q <= ov_d;
    end
  end
endmodule

// ===== src/graphic_eq_band_leg_filter_unit.sv =====
// Ten-band graphic equalizer of series-LC legs around a summing node, Q23.40.
// Opcode 0 words are audio samples and give one output word; opcode 1 writes a
// coefficient (80-entry RAM), opcode 2 clears leg state; both give nothing. A
// sample runs through one shared 64x64 multiplier, each product in steps (issue,
// four 32x32 partial products, round and saturate, done): 6 + 8*NUM_BANDS
// products, with a bookkeeping step ahead of each band's history product and of
// each band's leg pass, plus the accept and output steps.
// The result waits in an output register while the next word is taken; a
// sample that finishes while that register is still full stalls until it frees.
module graphic_eq_band_leg_filter_unit #(
  parameter int unsigned NUM_BANDS   = 10,
  parameter int unsigned SAMPLE_BITS = 24,
  parameter int unsigned FRAC_BITS   = 40
) (
  input  logic clk_i,
  input  logic rst_ni,
  geq_stream_if.sink   in_if,
  geq_stream_if.source out_if,
  geq_stream_if.sink   cfg_if
);
  logic [22:0] gain_q, vol_q;
  logic [31:0] iscale_q, hscale_q;

  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= 23'd1048576; vol_q <= 23'd1048576;
      iscale_q <= 32'd16777216; hscale_q <= 32'd16777216;
    end else if (cfg_if.valid) begin
      case (cfg_if.data.index)
        geq_pkg::CFG_IN_GAIN:    gain_q <= cfg_if.data.value[22:0];
        geq_pkg::CFG_VOLUME:     vol_q <= cfg_if.data.value[22:0];
        geq_pkg::CFG_IN_SCALE:   iscale_q <= cfg_if.data.value[31:0];
        geq_pkg::CFG_HIST_SCALE: hscale_q <= cfg_if.data.value[31:0];
        default: ;
      endcase
    end
  end

  logic cap, cwe, clr, hwe, oload, mdone;
  logic [$clog2(NUM_BANDS*geq_pkg::COEFS_PER_BAND)-1:0] craddr;
  logic [$clog2(NUM_BANDS)-1:0] bsel, hraddr;
  geq_pkg::mul_cmd_t mcmd;
  logic [3:0] op;

  geq_ctrl #(.NUM_BANDS(NUM_BANDS), .SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(in_if.valid), .opcode_i(in_if.data.opcode),
    .band_i(in_if.data.band_index), .in_ready_o(in_if.ready),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready), .cap_o(cap),
    .coef_we_o(cwe), .clear_o(clr), .coef_raddr_o(craddr), .band_sel_o(bsel),
    .hist_raddr_o(hraddr), .mul_cmd_o(mcmd), .op_o(op), .hist_we_o(hwe),
    .out_load_o(oload), .mul_done_i(mdone)
  );

  geq_datapath #(.NUM_BANDS(NUM_BANDS), .SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk_i, .rst_ni, .in_gain_i(gain_q), .volume_i(vol_q), .in_scale_i(iscale_q),
    .hist_scale_i(hscale_q), .cap_i(cap), .sample_i(in_if.data.sample_in),
    .band_i(in_if.data.band_index), .sel_i(in_if.data.coef_select),
    .value_i(in_if.data.coef_value), .coef_we_i(cwe), .clear_i(clr),
    .coef_raddr_i(craddr), .band_sel_i(bsel), .hist_raddr_i(hraddr), .mul_cmd_i(mcmd),
    .op_i(op), .hist_we_i(hwe), .out_load_i(oload), .mul_done_o(mdone),
    .sample_o(out_if.data.sample_out), .clipped_o(out_if.data.clipped)
  );
endmodule
